// ----- sv/ssm_pkg.sv -----
package ssm_pkg;

    // Default sizing
    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int START_W  = 16;
    localparam int OFFSET_W = 16;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_IGNORE_CASE     = 2'd0;
    localparam logic [1:0] REG_SEARCH_BACKWARD = 2'd1;
    localparam logic [1:0] REG_START_OFFSET    = 2'd2;

    // Command codes carried in tuser
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // ASCII letter bounds
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic        text_en;
        logic        clear;
        logic        ignore_case;
        logic [7:0]  text_byte;
    } cell_ctl_t;

    // Fold ASCII lowercase to uppercase when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c >= LOWER_A) && (c <= LOWER_Z))
        begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ----- sv/ssm_cell.sv -----
module ssm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ssm_pkg::cell_ctl_t ctl,
    input  logic               load_en,
    input  logic [7:0]         load_byte,
    input  logic               active,
    input  logic               prev_bit,
    output logic               match_bit,
    output logic               match_next
);
    import ssm_pkg::*;

    logic [BYTE_W-1:0] pattern_byte_reg;
    logic              match_bit_reg;
    logic              match_bit_next;

    // Hold one pattern byte
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            pattern_byte_reg <= load_byte;
        end
    end

    // Extend the neighbor's partial match by this position
    always_comb
    begin
        match_next = prev_bit && active &&
                     (fold_byte(pattern_byte_reg, ctl.ignore_case) == ctl.text_byte);
        match_bit_next = match_bit_reg;
        if (ctl.clear)
        begin
            match_bit_next = 1'b0;
        end
        else if (ctl.text_en)
        begin
            match_bit_next = match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_bit_reg <= 1'b0;
        end
        else
        begin
            match_bit_reg <= match_bit_next;
        end
    end

    assign match_bit = match_bit_reg;

endmodule

// ----- sv/substring_search_matcher_core.sv -----
// Streaming substring matcher.
// Input words arrive on the s_ channel: tuser selects pattern byte (0) or
// text byte (1), tdata carries the byte and tlast marks the final pattern
// byte or the final text byte. A pattern byte that follows a completed
// pattern or a text byte starts a new pattern; bytes beyond MAX_PATTERN are dropped.
// Each text byte goes to a chain of MAX_PATTERN cells, one per pattern
// position, that compare it in parallel and pass partial-match bits to
// their neighbor. One word is accepted per cycle, back to back, while s_tready is high.
// On the final text byte one result word appears on the m_ channel in the
// cycle after acceptance: found and the match start (first match at or
// after start_offset, or last at or before it when searching backward).
// Words without tlast on text produce no result.
// The result sits in an output register; while it waits, s_tready stays
// high only if m_tready is high, so a stalled receiver stalls the input.
// Reset clears the pattern length, the text state, the configuration registers and the output valid flag.
// Registers are written over the APB port; the user must write them only while the block is idle, not enforced here.
module substring_search_matcher_core #(
    parameter int MAX_PATTERN   = ssm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = ssm_pkg::POSITION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] cmd
    input  logic                            s_tlast,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssm_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] found, [16:1] match_start, zero pad
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssm_pkg::ADDR_W-1:0]      paddr,
    input  logic [ssm_pkg::APB_W-1:0]       pwdata,
    output logic [ssm_pkg::APB_W-1:0]       prdata,
    output logic                            pready
);
    import ssm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PB = POSITION_BITS;
    localparam int CW = (PB > OFFSET_W) ? PB : OFFSET_W;

    // Configuration registers
    logic                ignore_case_reg;
    logic                search_backward_reg;
    logic [OFFSET_W-1:0] start_offset_reg;

    // Pattern and text state
    logic [LW-1:0] len_reg, len_next;
    logic          done_reg, done_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic          seen_reg, seen_next;
    logic [PB-1:0] best_reg, best_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [START_W-1:0] out_start_reg, out_start_next;

    logic              accept;
    logic              is_text;
    logic              start_new;
    logic [LW-1:0]     widx;
    logic              store_ok;
    logic [BYTE_W-1:0] in_byte;
    cell_ctl_t         ctl;

    logic [MAX_PATTERN-1:0] load_vec;
    logic [MAX_PATTERN-1:0] active_vec;
    logic [MAX_PATTERN-1:0] tail_vec;
    logic [MAX_PATTERN-1:0] bits_reg;
    logic [MAX_PATTERN-1:0] bits_next;

    logic          hit;
    logic [PB-1:0] match_pos;
    logic [CW-1:0] match_pos_ext;
    logic [CW-1:0] offset_ext;
    logic [CW-1:0] best_ext;

    assign pready   = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_text  = (s_tuser == CMD_TEXT);
    assign in_byte  = s_tdata[BYTE_W-1:0];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg     <= 1'b0;
            search_backward_reg <= 1'b0;
            start_offset_reg    <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_IGNORE_CASE:     ignore_case_reg     <= pwdata[0];
                REG_SEARCH_BACKWARD: search_backward_reg <= pwdata[0];
                REG_START_OFFSET:    start_offset_reg    <= pwdata[OFFSET_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_IGNORE_CASE:     prdata[0] = ignore_case_reg;
            REG_SEARCH_BACKWARD: prdata[0] = search_backward_reg;
            REG_START_OFFSET:    prdata[OFFSET_W-1:0] = start_offset_reg;
            default:             prdata = '0;
        endcase
    end

    // Pattern write slot
    assign start_new = done_reg;
    assign widx      = start_new ? '0 : len_reg;
    assign store_ok  = (widx < LW'(MAX_PATTERN));

    // Broadcast to the cells
    always_comb
    begin
        ctl.text_en     = accept && is_text;
        ctl.clear       = accept && ((!is_text && start_new) || (is_text && s_tlast));
        ctl.ignore_case = ignore_case_reg;
        ctl.text_byte   = fold_byte(in_byte, ignore_case_reg);
    end

    // Chain of compare cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            logic prev_bit;

            if (gi == 0)
            begin : g_head
                assign prev_bit = 1'b1;
            end
            else
            begin : g_link
                assign prev_bit = bits_reg[gi-1];
            end

            assign load_vec[gi]   = accept && !is_text && store_ok && (widx == LW'(gi));
            assign active_vec[gi] = (LW'(gi) < len_reg);
            assign tail_vec[gi]   = (len_reg == LW'(gi + 1));

            ssm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .load_en    (load_vec[gi]),
                .load_byte  (in_byte),
                .active     (active_vec[gi]),
                .prev_bit   (prev_bit),
                .match_bit  (bits_reg[gi]),
                .match_next (bits_next[gi])
            );
        end
    endgenerate

    // Full match ends at this byte; its start position
    assign hit           = |(bits_next & tail_vec);
    assign match_pos     = pos_reg - PB'(len_reg - LW'(1));
    assign match_pos_ext = CW'(match_pos);
    assign offset_ext    = CW'(start_offset_reg);

    // Advance pattern and text state
    always_comb
    begin
        len_next       = len_reg;
        done_next      = done_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        best_next      = best_reg;
        best_ext       = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;

        if (accept && !is_text)
        begin
            if (start_new)
            begin
                pos_next  = '0;
                seen_next = 1'b0;
                best_next = '0;
            end
            len_next  = store_ok ? (widx + LW'(1)) : widx;
            done_next = s_tlast;
        end
        else if (accept)
        begin
            done_next = 1'b1;
            // Record a qualifying match
            if (hit)
            begin
                if (search_backward_reg)
                begin
                    if (match_pos_ext <= offset_ext)
                    begin
                        seen_next = 1'b1;
                        best_next = match_pos;
                    end
                end
                else if (!seen_reg && (match_pos_ext >= offset_ext))
                begin
                    seen_next = 1'b1;
                    best_next = match_pos;
                end
            end
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + PB'(1);
            end
            // Emit result and drop the text state
            if (s_tlast)
            begin
                best_ext       = CW'(best_next);
                out_valid_next = 1'b1;
                out_found_next = seen_next;
                out_start_next = seen_next ? best_ext[START_W-1:0] : '0;
                pos_next       = '0;
                seen_next      = 1'b0;
                best_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            done_reg      <= 1'b1;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            done_reg      <= done_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - START_W - 1){1'b0}}, out_start_reg, out_found_reg};

endmodule

// ----- verif/match_checker.sv -----
`timescale 1ns / 1ps

// Watch the input, result and register channels of the substring matcher,
// track the pattern and text state on every accepted word and compare each
// result word against the oldest predicted one.
module match_checker
    import ssm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [7:0] data_byte
    input  logic                   s_tuser,    // [0] cmd
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // [0] found, [16:1] match_start, zero pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_W-1:0]       pwdata,
    input  logic [APB_W-1:0]       prdata,
    input  logic                   pready,
    output int                     errors,
    output int                     results_due
);

    localparam int MAXP  = MAX_PATTERN_DEF;
    localparam int POS_W = POSITION_BITS_DEF;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } verdict_t;

    verdict_t          due_q[$];

    // Pattern and text state
    logic [BYTE_W-1:0] pat_mem [MAXP];
    int unsigned       pat_len;
    logic              pat_closed;
    logic [MAXP-1:0]   run_bits;
    logic [POS_W-1:0]  txt_pos;
    logic              hit;
    logic [POS_W-1:0]  hit_start;

    // Register shadows
    logic              fold_en;
    logic              back_en;
    logic [OFFSET_W-1:0] offset_reg;

    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
        if (fold_en && c >= "a" && c <= "z")
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    task automatic wipe_text();
        run_bits  = '0;
        txt_pos   = '0;
        hit       = 1'b0;
        hit_start = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("match_checker: %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Fold one accepted word into the state; queue a verdict on the last text byte
    task automatic advance_search(input logic cmd, input logic [BYTE_W-1:0] b,
                                  input logic lst);
        logic [BYTE_W-1:0] t;
        logic [MAXP-1:0]   eq;
        logic [POS_W-1:0]  s;
        verdict_t          v;
        if (cmd == CMD_PATTERN)
        begin
            if (pat_closed)
            begin
                pat_len    = 0;
                pat_closed = 1'b0;
                wipe_text();
            end
            if (pat_len < MAXP)
            begin
                pat_mem[pat_len] = b;
                pat_len++;
            end
            if (lst)
            begin
                pat_closed = 1'b1;
            end
        end
        else
        begin
            pat_closed = 1'b1;
            t  = upcase(b);
            eq = '0;
            for (int i = 0; i < MAXP; i++)
            begin
                if (i < pat_len)
                begin
                    if (upcase(pat_mem[i]) == t)
                    begin
                        eq[i] = 1'b1;
                    end
                end
            end
            run_bits = ((run_bits << 1) | 1) & eq;
            if (pat_len > 0 && run_bits[pat_len-1])
            begin
                s = txt_pos - POS_W'(pat_len - 1);
                if (back_en)
                begin
                    if (s <= offset_reg)
                    begin
                        hit       = 1'b1;
                        hit_start = s;
                    end
                end
                else if (!hit && s >= offset_reg)
                begin
                    hit       = 1'b1;
                    hit_start = s;
                end
            end
            // Saturate the position at its top value
            if (txt_pos != '1)
            begin
                txt_pos++;
            end
            if (lst)
            begin
                v.found = hit;
                v.start = hit ? START_W'(hit_start) : '0;
                due_q.push_back(v);
                wipe_text();
            end
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pat_len    = 0;
            pat_closed = 1'b1;
            fold_en    = 1'b0;
            back_en    = 1'b0;
            offset_reg = '0;
            wipe_text();
            due_q.delete();
        end
        else
        begin
            // Track register writes, check readback
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_IGNORE_CASE:     fold_en    = pwdata[0];
                        REG_SEARCH_BACKWARD: back_en    = pwdata[0];
                        REG_START_OFFSET:    offset_reg = pwdata[OFFSET_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        REG_IGNORE_CASE:
                            if (prdata !== 32'(fold_en))
                                report_mismatch("ignore_case readback", prdata, 32'(fold_en));
                        REG_SEARCH_BACKWARD:
                            if (prdata !== 32'(back_en))
                                report_mismatch("search_backward readback", prdata,
                                                32'(back_en));
                        REG_START_OFFSET:
                            if (prdata !== 32'(offset_reg))
                                report_mismatch("start_offset readback", prdata,
                                                32'(offset_reg));
                        default: ;
                    endcase
                end
            end
            // Compare a delivered result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (due_q.size() == 0)
                begin
                    report_mismatch("result word with none pending", 32'(m_tdata), 32'h0);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch("found", 32'(m_tdata[0]), 32'(want.found));
                    if (m_tdata[START_W:1] !== want.start)
                        report_mismatch("match_start", 32'(m_tdata[START_W:1]),
                                        32'(want.start));
                    if (m_tdata[OUT_TDATA_W-1:START_W+1] !== '0)
                        report_mismatch("pad bits", 32'(m_tdata[OUT_TDATA_W-1:START_W+1]),
                                        32'h0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_search(s_tuser, s_tdata[BYTE_W-1:0], s_tlast);
            end
        end
        results_due = due_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ssm_pkg::*;

    localparam int         QUIET_LIMIT = 5000;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [7:0] data_byte
    logic                   s_tuser;    // [0] cmd
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [0] found, [16:1] match_start, zero pad
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [APB_W-1:0]       pwdata;
    logic [APB_W-1:0]       prdata;
    logic                   pready;

    int                snd_idle;
    int                rcv_idle;
    int                base_snd;
    int                base_rcv;
    int                words_sent;
    int                quiet;
    int                mismatches;
    int                results_due;
    logic [BYTE_W-1:0] cur_pattern[$];

    substring_search_matcher_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    match_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (mismatches),
        .results_due (results_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Offer one word, idling first at random; return at its acceptance edge
    task automatic put_word(input logic cmd, input logic [BYTE_W-1:0] b, input logic lst);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic put_string(input logic cmd, input string str, input logic lst);
        for (int i = 0; i < str.len(); i++)
        begin
            put_word(cmd, str[i], lst && (i == str.len() - 1));
        end
    endtask

    // Drop valid and wait until every result is out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program all three registers with junk in the unused upper bits, then read back
    task automatic set_config(input logic fold, input logic back, input logic [15:0] off);
        logic [31:0] v;
        v = $urandom;
        v[0] = fold;
        apb_xfer(1'b1, REG_IGNORE_CASE, v);
        v = $urandom;
        v[0] = back;
        apb_xfer(1'b1, REG_SEARCH_BACKWARD, v);
        v = $urandom;
        v[15:0] = off;
        apb_xfer(1'b1, REG_START_OFFSET, v);
        apb_xfer(1'b0, REG_IGNORE_CASE, '0);
        apb_xfer(1'b0, REG_SEARCH_BACKWARD, '0);
        apb_xfer(1'b0, REG_START_OFFSET, '0);
    endtask

    // Mostly a small alphabet of letters so that matches happen
    function automatic logic [BYTE_W-1:0] pick_char();
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 3))
                0: return "a";
                1: return "A";
                2: return "b";
                default: return "B";
            endcase
        end
        return 8'($urandom);
    endfunction

    // One random job: noise, a broken sequence, or a pattern and a text
    task automatic run_job();
        int                r;
        int                n;
        int                at;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] txt[$];
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        if (r < 10)
        begin
            repeat ($urandom_range(1, 4))
                put_word(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        end
        else
        begin
            // New pattern; 10..17 leaves it open so text ends the loading
            if (r < 55 || cur_pattern.size() == 0)
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 5);
                cur_pattern = {};
                for (int i = 0; i < n; i++)
                begin
                    c = pick_char();
                    cur_pattern.push_back(c);
                    put_word(CMD_PATTERN, c, (i == n - 1) && (r >= 18));
                end
            end
            n = $urandom_range(1, 24);
            if (cur_pattern.size() > 20)
            begin
                n = cur_pattern.size() + $urandom_range(0, 4);
            end
            txt = {};
            repeat (n) txt.push_back(pick_char());
            // Plant the pattern, flipping letter case at random
            if (cur_pattern.size() <= n && $urandom_range(0, 9) < 7)
            begin
                at = $urandom_range(0, n - cur_pattern.size());
                foreach (cur_pattern[i])
                begin
                    c = cur_pattern[i];
                    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                        && $urandom_range(0, 1))
                    begin
                        c = c ^ 8'h20;
                    end
                    txt[at + i] = c;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                // 10..13 drops a new pattern byte into the middle of the text
                if (r < 14 && i == n / 2)
                begin
                    c = pick_char();
                    cur_pattern = {c};
                    put_word(CMD_PATTERN, c, 1'b1);
                end
                put_word(CMD_TEXT, txt[i], i == n - 1);
            end
        end
        snd_idle = base_snd;
        rcv_idle = base_rcv;
    endtask

    initial
    begin
        int               target;
        int               k;
        logic [15:0]      off;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_PATTERN;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        base_snd = 35;
        base_rcv = 73;
        snd_idle = base_snd;
        rcv_idle = base_rcv;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: text with no pattern loaded never matches
        put_word(CMD_TEXT, "A", 1'b1);
        // Extreme bytes
        put_word(CMD_PATTERN, 8'hFF, 1'b1);
        put_word(CMD_TEXT, 8'h00, 1'b0);
        put_word(CMD_TEXT, 8'hFF, 1'b1);
        // Plain forward search, case sensitive
        put_string(CMD_PATTERN, "Ab", 1'b1);
        put_string(CMD_TEXT, "xAbAb", 1'b1);
        // Text arriving while the pattern is still open
        put_word(CMD_PATTERN, "C", 1'b0);
        put_word(CMD_TEXT, "C", 1'b1);
        // New pattern in the middle of a text clears the text
        put_word(CMD_TEXT, "z", 1'b0);
        put_word(CMD_PATTERN, "z", 1'b1);
        put_word(CMD_TEXT, "z", 1'b1);
        quiesce();
        // Folded, backward from the top offset; unused index is ignored
        set_config(1'b1, 1'b1, 16'hFFFF);
        apb_xfer(1'b1, REG_UNUSED, $urandom);
        put_string(CMD_PATTERN, "aB", 1'b1);
        put_string(CMD_TEXT, "AbaB", 1'b1);

        // Random: three idling profiles, four register settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin base_snd = 35; base_rcv = 73; end
                1: begin base_snd = 73; base_rcv = 35; end
                default: begin base_snd = 0; base_rcv = 0; end
            endcase
            snd_idle = base_snd;
            rcv_idle = base_rcv;
            for (int blk = 0; blk < 4; blk++)
            begin
                k = ph * 4 + blk;
                case (k % 5)
                    0: off = 16'h0000;
                    1: off = 16'hFFFF;
                    4: off = 16'($urandom);
                    default: off = 16'($urandom_range(0, 24));
                endcase
                quiesce();
                set_config(k[0], k[1], off);
                target = words_sent + 60;
                while (words_sent < target)
                begin
                    run_job();
                end
            end
        end

        quiesce();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
